### rtl/pf2b_pkg.sv
package pf2b_pkg;

  // source pixel layouts selected by the format register
  typedef enum logic [1:0] {
    FMT_BGRA8   = 2'd0,
    FMT_RGBA8   = 2'd1,
    FMT_RGB10A2 = 2'd2,
    FMT_RGBA16F = 2'd3
  } src_fmt_e;

  localparam int unsigned PixelWidth = 64;
  localparam int unsigned ChanWidth  = 8;
  localparam int unsigned HalfWidth  = 16;

  // all-ones half exponent marks infinity and nan
  localparam logic [4:0] HalfExpSpecial = 5'h1F;
  // biased exponent of 1.0
  localparam logic [4:0] HalfExpOne     = 5'd15;
  // right shift base: value = (1024+m) * 2^(e-25)
  localparam logic [4:0] HalfShiftBase  = 5'd25;

  localparam logic [ChanWidth-1:0] ChanZero = '0;
  localparam logic [ChanWidth-1:0] ChanFull = '1;

endpackage

### rtl/pixel_format_to_bgra8.sv
// a pixel taken at a clock edge is held in the input register, converted, and held in the
//   result register while its strobe is raised; the receiver takes it while the strobe is high
// throughput: one pixel per clock; input register and result register with one
//   conversion stage between them, so busy stays low
// results are strobed for one cycle and cannot be stalled by the receiver
// reset (rst_ni low, asynchronous) drops pixels in flight and sets the format to bgra8
module pixel_format_to_bgra8 (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [pf2b_pkg::PixelWidth-1:0]     pixel_word_i,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [1:0]                          cfg_data_i,
  output logic                                out_strobe_o,
  output logic [pf2b_pkg::ChanWidth-1:0]      blue_o,
  output logic [pf2b_pkg::ChanWidth-1:0]      green_o,
  output logic [pf2b_pkg::ChanWidth-1:0]      red_o,
  output logic [pf2b_pkg::ChanWidth-1:0]      alpha_o
);

  pf2b_pkg::src_fmt_e                  fmt_q;
  logic                                in_valid_q;
  logic [pf2b_pkg::PixelWidth-1:0]     pixel_q;
  logic [pf2b_pkg::ChanWidth-1:0]      half_r;
  logic [pf2b_pkg::ChanWidth-1:0]      half_g;
  logic [pf2b_pkg::ChanWidth-1:0]      half_b;
  logic [pf2b_pkg::ChanWidth-1:0]      blue_d, green_d, red_d;
  logic [pf2b_pkg::ChanWidth-1:0]      blue_q, green_q, red_q;
  logic                                strobe_q;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  // format register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= pf2b_pkg::FMT_BGRA8;
    end else if (cfg_valid_i && cfg_ready_o) begin
      fmt_q <= pf2b_pkg::src_fmt_e'(cfg_data_i);
    end
  end

  // input stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      strobe_q   <= 1'b0;
    end else begin
      in_valid_q <= start && !busy;
      strobe_q   <= in_valid_q;
    end
  end

  // input stage payload
  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      pixel_q <= pixel_word_i;
    end
  end

  // half float channels
  pf2b_half_cvt u_half_r (.half_i(pixel_q[15:0]),  .unorm_o(half_r));
  pf2b_half_cvt u_half_g (.half_i(pixel_q[31:16]), .unorm_o(half_g));
  pf2b_half_cvt u_half_b (.half_i(pixel_q[47:32]), .unorm_o(half_b));

  // channel selection per source format
  always_comb begin
    unique case (fmt_q)
      pf2b_pkg::FMT_RGBA8: begin
        red_d   = pixel_q[7:0];
        green_d = pixel_q[15:8];
        blue_d  = pixel_q[23:16];
      end
      pf2b_pkg::FMT_RGB10A2: begin
        red_d   = pixel_q[9:2];
        green_d = pixel_q[19:12];
        blue_d  = pixel_q[29:22];
      end
      pf2b_pkg::FMT_RGBA16F: begin
        red_d   = half_r;
        green_d = half_g;
        blue_d  = half_b;
      end
      default: begin
        blue_d  = pixel_q[7:0];
        green_d = pixel_q[15:8];
        red_d   = pixel_q[23:16];
      end
    endcase
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (in_valid_q) begin
      blue_q  <= blue_d;
      green_q <= green_d;
      red_q   <= red_d;
    end
  end

  assign out_strobe_o = strobe_q;
  assign blue_o       = blue_q;
  assign green_o      = green_q;
  assign red_o        = red_q;
  assign alpha_o      = pf2b_pkg::ChanFull;

endmodule

### rtl/pf2b_half_cvt.sv
module pf2b_half_cvt (
  input  logic [pf2b_pkg::HalfWidth-1:0] half_i,
  output logic [pf2b_pkg::ChanWidth-1:0] unorm_o
);

  logic        sign;
  logic [4:0]  expo;
  logic [9:0]  mant;
  logic [10:0] signif;
  logic [18:0] prod;
  logic [4:0]  shamt;
  logic [23:0] rnd;
  logic [23:0] sum;
  logic [23:0] scaled;

  assign sign = half_i[15];
  assign expo = half_i[14:10];
  assign mant = half_i[9:0];

  // significand times 255 as (x << 8) - x
  assign signif = {1'b1, mant};
  assign prod   = {signif, 8'h00} - {8'h00, signif};

  // round half up, then shift by 25 - e (11 to 24 for normal values below one)
  assign shamt  = pf2b_pkg::HalfShiftBase - expo;
  assign rnd    = 24'd1 << (shamt - 5'd1);
  assign sum    = {5'b0, prod} + rnd;
  assign scaled = sum >> shamt;

  // clamp to [0,1]; nan, negatives, zero and denormals give zero
  always_comb begin
    priority if (sign || expo == 5'd0) begin
      unorm_o = pf2b_pkg::ChanZero;
    end else if (expo == pf2b_pkg::HalfExpSpecial) begin
      unorm_o = (mant != 10'd0) ? pf2b_pkg::ChanZero : pf2b_pkg::ChanFull;
    end else if (expo >= pf2b_pkg::HalfExpOne) begin
      unorm_o = pf2b_pkg::ChanFull;
    end else begin
      unorm_o = scaled[7:0];
    end
  end

endmodule

### rtl/pf2b_checker.sv
module pf2b_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic       cfg_valid_i,
  input logic       cfg_ready_o,
  input logic       out_strobe_o,
  input logic [7:0] alpha_o
);

  // every accepted pixel gives a result strobe after the input and result registers
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> ##1 out_strobe_o)
    else $error("accepted pixel produced no result");

  // no result without a pixel accepted ahead of it through the input and result registers
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_strobe_o |-> $past(start && !busy && rst_ni, 2))
    else $error("result strobe without accepted pixel");

  // alpha is opaque on every result
  a_alpha_opaque: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_strobe_o |-> alpha_o == 8'hFF)
    else $error("alpha not opaque");

  // pixels and format writes are taken every cycle
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy && cfg_ready_o)
    else $error("block stalled an input");

endmodule

bind pixel_format_to_bgra8 pf2b_checker u_pf2b_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .cfg_valid_i  (cfg_valid_i),
  .cfg_ready_o  (cfg_ready_o),
  .out_strobe_o (out_strobe_o),
  .alpha_o      (alpha_o)
);

### sim/tb_pixel_format_to_bgra8.sv
module tb_pixel_format_to_bgra8;

  typedef struct packed {
    logic [pf2b_pkg::ChanWidth-1:0] blue;
    logic [pf2b_pkg::ChanWidth-1:0] green;
    logic [pf2b_pkg::ChanWidth-1:0] red;
    logic [pf2b_pkg::ChanWidth-1:0] alpha;
  } bgra_t;

  logic                            clk_i;
  logic                            rst_ni;
  logic                            start;
  logic                            busy;
  logic [pf2b_pkg::PixelWidth-1:0] pixel_word_i;
  logic                            cfg_valid_i;
  logic                            cfg_ready_o;
  logic [1:0]                      cfg_data_i;
  logic                            out_strobe_o;
  logic [pf2b_pkg::ChanWidth-1:0]  blue_o;
  logic [pf2b_pkg::ChanWidth-1:0]  green_o;
  logic [pf2b_pkg::ChanWidth-1:0]  red_o;
  logic [pf2b_pkg::ChanWidth-1:0]  alpha_o;

  // expected converted pixels, oldest first
  bgra_t               pending_bgra[$];
  bgra_t               next_bgra;
  pf2b_pkg::src_fmt_e  model_fmt;
  int                  fail_count;
  bit                  no_gaps;

  pixel_format_to_bgra8 u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .pixel_word_i (pixel_word_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .out_strobe_o (out_strobe_o),
    .blue_o       (blue_o),
    .green_o      (green_o),
    .red_o        (red_o),
    .alpha_o      (alpha_o)
  );

  // clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // half float channel to 8-bit unorm, clamped to [0,1], round half up
  function automatic logic [pf2b_pkg::ChanWidth-1:0] half_to_chan(
    input logic [pf2b_pkg::HalfWidth-1:0] h
  );
    logic [4:0]  ex;
    logic [9:0]  man;
    logic [31:0] prod;
    int unsigned sh;
    ex  = h[14:10];
    man = h[9:0];
    if (h[15] || ex == 5'd0) return pf2b_pkg::ChanZero;
    if (ex == pf2b_pkg::HalfExpSpecial)
      return (man != 10'd0) ? pf2b_pkg::ChanZero : pf2b_pkg::ChanFull;
    if (ex >= pf2b_pkg::HalfExpOne) return pf2b_pkg::ChanFull;
    prod = (32'd1024 + 32'(man)) * 32'd255;
    sh   = 32'(pf2b_pkg::HalfShiftBase) - 32'(ex);
    prod = (prod + (32'd1 << (sh - 1))) >> sh;
    return prod[pf2b_pkg::ChanWidth-1:0];
  endfunction

  // expected bgra8 output for one source pixel
  function automatic bgra_t convert_pixel(
    input pf2b_pkg::src_fmt_e fmt,
    input logic [pf2b_pkg::PixelWidth-1:0] p
  );
    bgra_t px;
    px.alpha = pf2b_pkg::ChanFull;
    case (fmt)
      pf2b_pkg::FMT_RGBA8: begin
        px.red   = p[7:0];
        px.green = p[15:8];
        px.blue  = p[23:16];
      end
      pf2b_pkg::FMT_RGB10A2: begin
        px.red   = p[9:2];
        px.green = p[19:12];
        px.blue  = p[29:22];
      end
      pf2b_pkg::FMT_RGBA16F: begin
        px.red   = half_to_chan(p[15:0]);
        px.green = half_to_chan(p[31:16]);
        px.blue  = half_to_chan(p[47:32]);
      end
      default: begin
        px.blue  = p[7:0];
        px.green = p[15:8];
        px.red   = p[23:16];
      end
    endcase
    return px;
  endfunction

  // random half, biased toward positive normals in (0,1)
  function automatic logic [pf2b_pkg::HalfWidth-1:0] rand_half();
    logic [pf2b_pkg::HalfWidth-1:0] h;
    h = pf2b_pkg::HalfWidth'($urandom);
    if ($urandom_range(0, 3) != 0) begin
      h[15]    = ($urandom_range(0, 7) == 0);
      h[14:10] = 5'($urandom_range(1, 14));
    end
    return h;
  endfunction

  function automatic logic [pf2b_pkg::PixelWidth-1:0] rand_pixel(
    input pf2b_pkg::src_fmt_e fmt
  );
    case ($urandom_range(0, 31))
      0:       return '0;
      1:       return '1;
      default: begin
        if (fmt == pf2b_pkg::FMT_RGBA16F)
          return {16'($urandom), rand_half(), rand_half(), rand_half()};
        return {$urandom, $urandom};
      end
    endcase
  endfunction

  // one pixel transfer, with a random idle gap first
  task automatic send_pixel(input logic [pf2b_pkg::PixelWidth-1:0] pix);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 9);
    @(negedge clk_i);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start        <= 1'b1;
    pixel_word_i <= pix;
    do @(posedge clk_i); while (busy);
    pending_bgra.push_back(convert_pixel(model_fmt, pix));
  endtask

  // stop sending and wait for every expected pixel to come back
  task automatic wait_results_idle();
    int n;
    @(negedge clk_i);
    start <= 1'b0;
    for (n = 0; n < 200 && pending_bgra.size() != 0; n++) @(posedge clk_i);
    if (pending_bgra.size() != 0) begin
      $display("%0t: %0d expected pixels never came out", $time, pending_bgra.size());
      fail_count++;
      pending_bgra.delete();
    end
    repeat (4) @(posedge clk_i);
  endtask

  // format register write, only while the pipeline is empty
  task automatic set_source_format(input pf2b_pkg::src_fmt_e fmt);
    wait_results_idle();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= fmt;
    do @(posedge clk_i); while (!cfg_ready_o);
    model_fmt = fmt;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic check_chan(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %02h actual %02h", $time, name, want, got);
    end
  endtask

  // compare each strobed result with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_strobe_o) begin
      if (pending_bgra.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected result, expected none actual %02h%02h%02h%02h",
                 $time, blue_o, green_o, red_o, alpha_o);
      end else begin
        next_bgra = pending_bgra.pop_front();
        check_chan("blue",  next_bgra.blue,  blue_o);
        check_chan("green", next_bgra.green, green_o);
        check_chan("red",   next_bgra.red,   red_o);
        check_chan("alpha", next_bgra.alpha, alpha_o);
      end
    end
  end

  // bgra8 is the reset format, no register write yet
  task automatic test_reset_default();
    send_pixel('0);
    send_pixel('1);
    send_pixel(64'hA5A5_5A5A_00C3_3CF0);
  endtask

  task automatic test_rgba8();
    set_source_format(pf2b_pkg::FMT_RGBA8);
    send_pixel(64'hDEAD_BEEF_7F80_01FE);
    send_pixel(64'h0000_0000_FF00_00FF);
    send_pixel('1);
  endtask

  task automatic test_rgb10a2();
    set_source_format(pf2b_pkg::FMT_RGB10A2);
    send_pixel('0);
    send_pixel('1);
    send_pixel(64'h1234_5678_2AA5_5003);
    send_pixel(64'hFFFF_FFFF_C000_0000);
  endtask

  // zeros, denormals, rounding, one and above, infinities, nan, negatives
  task automatic test_half_float();
    set_source_format(pf2b_pkg::FMT_RGBA16F);
    send_pixel({16'hFFFF, 16'h03FF, 16'h8000, 16'h0000});
    send_pixel({16'h0000, 16'h3BFF, 16'h3800, 16'h0400});
    send_pixel({16'h3C00, 16'h7C00, 16'h7BFF, 16'h3C00});
    send_pixel({16'h7E00, 16'hBC00, 16'h7E00, 16'hFC00});
    send_pixel({16'hFFFF, 16'h2C00, 16'h0001, 16'h3555});
    send_pixel({16'h0000, 16'h7FFF, 16'h1C01, 16'h3BFE});
  endtask

  task automatic test_bgra8_after_write();
    set_source_format(pf2b_pkg::FMT_BGRA8);
    send_pixel(64'h0123_4567_89AB_CDEF);
    send_pixel(64'hFEDC_BA98_7654_3210);
  endtask

  // random pixels in phases, first through every format in turn, then in random formats
  task automatic test_random_traffic();
    int                 sent;
    int                 phase;
    int                 phase_len;
    pf2b_pkg::src_fmt_e fmt;
    sent  = 0;
    phase = 0;
    while (sent < 1300) begin
      fmt = (phase < 4) ? pf2b_pkg::src_fmt_e'(phase)
                        : pf2b_pkg::src_fmt_e'($urandom_range(0, 3));
      set_source_format(fmt);
      no_gaps   = ($urandom_range(0, 3) == 0);
      phase_len = $urandom_range(40, 140);
      repeat (phase_len) begin
        send_pixel(rand_pixel(fmt));
        sent++;
        if ($urandom_range(0, 149) == 0) wait_results_idle();
      end
      phase++;
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    clk_i        = 1'b0;
    rst_ni       = 1'b0;
    start        = 1'b0;
    pixel_word_i = '0;
    cfg_valid_i  = 1'b0;
    cfg_data_i   = pf2b_pkg::FMT_BGRA8;
    model_fmt    = pf2b_pkg::FMT_BGRA8;
    fail_count   = 0;
    no_gaps      = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_default();
    test_rgba8();
    test_rgb10a2();
    test_half_float();
    test_bgra8_after_write();
    test_random_traffic();

    wait_results_idle();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

### files.f
rtl/pf2b_pkg.sv
rtl/pf2b_half_cvt.sv
rtl/pixel_format_to_bgra8.sv
rtl/pf2b_checker.sv
sim/tb_pixel_format_to_bgra8.sv
